>>> sv/lkvc_pkg.sv
// Shared types and constants for the LRU key-value cache.
`timescale 1ns / 1ps
package lkvc_pkg;

	// Width of the capacity register.
	localparam int unsigned CAP_W = 5;

	// Capacity after reset.
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// Keys and values are 32-bit two's complement words.
	typedef logic signed [31:0] word_t;

	// Value reported by a get that misses.
	localparam word_t READ_MISS = 32'shFFFF_FFFF;

	// Value reported for a set.
	localparam word_t READ_SET = 32'sh0000_0000;

	// Request commands.
	typedef enum logic {
		CMD_GET = 1'b0,
		CMD_SET = 1'b1
	} cmd_t;

	// One stored key and its value.
	typedef struct packed {
		word_t key;
		word_t value;
	} kv_t;

endpackage

>>> sv/lkvc_req_if.sv
// Request and response channel interfaces of the LRU key-value cache.
`timescale 1ns / 1ps
interface lkvc_req_if;
	logic               valid;
	logic               ready;
	lkvc_pkg::cmd_t     command;
	lkvc_pkg::word_t    key;
	lkvc_pkg::word_t    value;

	modport source (output valid, output command, output key, output value, input ready);
	modport sink (input valid, input command, input key, input value, output ready);
endinterface

interface lkvc_rsp_if;
	logic               valid;
	logic               ready;
	logic               hit;
	lkvc_pkg::word_t    read_value;

	modport source (output valid, output hit, output read_value, input ready);
	modport sink (input valid, input hit, input read_value, output ready);
endinterface

>>> sv/lkvc_store.sv
// Key and value storage: one write port and one registered read port.
`timescale 1ns / 1ps
module lkvc_store #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4
) (
	input  logic             clk,
	input  logic [AW-1:0]    rd_addr,
	output lkvc_pkg::kv_t    rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  lkvc_pkg::kv_t    wr_data
);
	import lkvc_pkg::*;

	kv_t mem_q [DEPTH];

	// Registered read and single write into the entry array.
	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

endmodule

>>> sv/lru_key_value_cache_unit.sv
// Top level of the fully associative LRU key-value cache.
`timescale 1ns / 1ps
// A fully associative store of up to CAPACITY_MAX key-value pairs in recency
// order. A get returns hit and the stored value (or no hit and -1) and makes
// the entry most recent; a set of a new key inserts it as most recent, first
// evicting the least recent entries while the store holds capacity entries or
// more; a set of a stored key changes nothing and returns zero. For each
// request the single read port of the key memory is swept one entry a cycle,
// followed by a drain state for the read and an update state that applies the
// recency update. A new request is taken while the previous response still
// waits in the output register. Capacity is to be written only while idle; the
// block itself does not enforce it. Zero acts as one and values above
// CAPACITY_MAX act as CAPACITY_MAX.
module lru_key_value_cache_unit #(
	parameter int unsigned CAPACITY_MAX = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lkvc_pkg::CAP_W-1:0]     cfg_wdata,
	lkvc_req_if.sink                       req,
	lkvc_rsp_if.source                     rsp
);
	import lkvc_pkg::*;

	localparam int unsigned RW = (CAPACITY_MAX > 1) ? $clog2(CAPACITY_MAX) : 1;
	localparam int unsigned FW = $clog2(CAPACITY_MAX + 1);
	localparam int unsigned CW = (FW > CAP_W) ? FW : CAP_W;
	localparam logic [RW-1:0] LAST = RW'(CAPACITY_MAX - 1);
	localparam logic [CW-1:0] CAP_MAX_C = CW'(CAPACITY_MAX);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_UPDATE
	} state_t;

	state_t            state_q;
	logic [CAP_W-1:0]  capacity_q;
	logic              valid_q [CAPACITY_MAX];
	logic [RW-1:0]     rank_q [CAPACITY_MAX];
	logic [FW-1:0]     fill_q;

	cmd_t              cmd_q;
	word_t             key_q;
	word_t             value_q;
	logic [RW-1:0]     ptr_q;

	logic              scan_s1;
	logic [RW-1:0]     ptr_s1;
	logic              valid_s1;
	logic [RW-1:0]     rank_s1;
	kv_t               rd_data;

	logic              found_q;
	logic [RW-1:0]     hit_idx_q;
	logic [RW-1:0]     hit_rank_q;
	word_t             hit_value_q;
	logic              free_found_q;
	logic [RW-1:0]     free_idx_q;

	logic              out_valid_q;
	logic              hit_q;
	word_t             read_value_q;

	logic [CW-1:0]     cap_ext;
	logic [CW-1:0]     eff_cap;
	logic [RW-1:0]     cap_m1;
	logic              fill_full;
	logic              proceed;
	logic              insert;
	logic              key_match;
	kv_t               wr_data;
	logic [CAPACITY_MAX-1:0] valid_vec;

	// Effective capacity and the rank from which entries get evicted.
	always_comb begin
		cap_ext = CW'(capacity_q);
		if (cap_ext == '0) begin
			eff_cap = CW'(1);
		end else if (cap_ext > CAP_MAX_C) begin
			eff_cap = CAP_MAX_C;
		end else begin
			eff_cap = cap_ext;
		end
		cap_m1    = RW'(eff_cap - CW'(1));
		fill_full = CW'(fill_q) >= eff_cap;
	end

	// Valid bits gathered into one vector for counting.
	always_comb begin
		for (int i = 0; i < CAPACITY_MAX; i++) begin
			valid_vec[i] = valid_q[i];
		end
	end

	// The update cycle waits until the output register is free.
	assign proceed   = (state_q == S_UPDATE) && (!out_valid_q || rsp.ready);
	assign insert    = proceed && (cmd_q == CMD_SET) && !found_q;
	assign key_match = scan_s1 && valid_s1 && (rd_data.key == key_q);
	assign wr_data   = '{key: key_q, value: value_q};

	assign req.ready      = (state_q == S_IDLE);
	assign rsp.valid      = out_valid_q;
	assign rsp.hit        = hit_q;
	assign rsp.read_value = read_value_q;

	lkvc_store #(
		.DEPTH (CAPACITY_MAX),
		.AW    (RW)
	) u_store (
		.clk     (clk),
		.rd_addr (ptr_q),
		.rd_data (rd_data),
		.wr_en   (insert),
		.wr_addr (free_idx_q),
		.wr_data (wr_data)
	);

	// Sequencer, recency ranks, valid bits and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			capacity_q   <= CAP_RESET;
			fill_q       <= '0;
			ptr_q        <= '0;
			scan_s1      <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			out_valid_q  <= 1'b0;
			for (int i = 0; i < CAPACITY_MAX; i++) begin
				valid_q[i] <= 1'b0;
				rank_q[i]  <= '0;
			end
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end

			// Stage one of the sweep: flags of the entry being read.
			scan_s1  <= (state_q == S_SCAN);
			ptr_s1   <= ptr_q;
			valid_s1 <= valid_q[ptr_q];
			rank_s1  <= rank_q[ptr_q];

			// Compare the read key and look for the first free or evictable slot.
			if (key_match && !found_q) begin
				found_q     <= 1'b1;
				hit_idx_q   <= ptr_s1;
				hit_rank_q  <= rank_s1;
				hit_value_q <= rd_data.value;
			end
			if (scan_s1 && !free_found_q && (!valid_s1 || rank_s1 >= cap_m1)) begin
				free_found_q <= 1'b1;
				free_idx_q   <= ptr_s1;
			end

			// A waiting response leaves when the sink takes it.
			if (rsp.ready && !proceed) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						cmd_q        <= req.command;
						key_q        <= req.key;
						value_q      <= req.value;
						ptr_q        <= '0;
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
						state_q      <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (ptr_q == LAST) begin
						state_q <= S_DRAIN;
					end else begin
						ptr_q <= ptr_q + RW'(1);
					end
				end
				S_DRAIN: begin
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					if (proceed) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
						if (cmd_q == CMD_GET) begin
							hit_q        <= found_q;
							read_value_q <= found_q ? hit_value_q : READ_MISS;
							// Entries more recent than the hit age by one step.
							if (found_q) begin
								for (int i = 0; i < CAPACITY_MAX; i++) begin
									if (RW'(i) == hit_idx_q) begin
										rank_q[i] <= '0;
									end else if (valid_q[i] && rank_q[i] < hit_rank_q) begin
										rank_q[i] <= rank_q[i] + RW'(1);
									end
								end
							end
						end else begin
							hit_q        <= 1'b0;
							read_value_q <= READ_SET;
							// Evict the oldest entries, age the rest, insert the new key.
							if (!found_q) begin
								for (int i = 0; i < CAPACITY_MAX; i++) begin
									if (RW'(i) == free_idx_q) begin
										valid_q[i] <= 1'b1;
										rank_q[i]  <= '0;
									end else if (valid_q[i] && rank_q[i] >= cap_m1) begin
										valid_q[i] <= 1'b0;
										rank_q[i]  <= '0;
									end else if (valid_q[i]) begin
										rank_q[i] <= rank_q[i] + RW'(1);
									end
								end
								fill_q <= fill_full ? FW'(eff_cap) : fill_q + FW'(1);
							end
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The fill count always equals the number of valid entries.
	a_fill_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == fill_q)
		else $error("fill count differs from number of valid entries");

	// An inserted key is valid and most recent right after the update.
	a_insert_most_recent: assert property (@(posedge clk) disable iff (!arst_n)
		insert |=> (valid_q[free_idx_q] && rank_q[free_idx_q] == '0))
		else $error("inserted entry is not valid and most recent");

	// A hit on get leaves the found entry most recent.
	a_hit_most_recent: assert property (@(posedge clk) disable iff (!arst_n)
		(proceed && cmd_q == CMD_GET && found_q) |=> (rank_q[hit_idx_q] == '0))
		else $error("entry hit by get is not most recent");

	// The fill count never exceeds the effective capacity after an insert.
	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		insert |=> (CW'(fill_q) <= eff_cap))
		else $error("fill count exceeds capacity after insert");

endmodule
